/* sv/assert_macros.svh */
// assertion macros used by nearest_codeword_search
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define NCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define NCS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define NCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/ncs_pkg.sv */
// shared types and constants of the nearest codeword search block
// no dependencies
package ncs_pkg;
	localparam int DEF_MAX_CODEWORDS = 256;
	localparam int DEF_MAX_DIM       = 16;
	localparam int DEF_SAMPLE_BITS   = 8;
	localparam int DIST_W            = 20;
	localparam int CFG_DATA_W        = 9;
	localparam int CFG_IDX_W         = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_CODEWORD_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH  = 1'd1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN, S_DONE} ncs_state_t;

	typedef struct packed {
		logic       ld_we;
		logic       q_we;
		logic [7:0] cw;
		logic [3:0] elem;
		logic [7:0] sample;
	} ncs_wr_t;
endpackage

/* sv/ncs_if.sv */
// item channels of the nearest codeword search block
// no dependencies
interface ncs_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] codeword_index;
	logic [3:0] element_index;
	logic [7:0] sample_value;
	logic       last_element;
	modport source (output valid, cmd, codeword_index, element_index, sample_value,
		last_element, input ready);
	modport sink (input valid, cmd, codeword_index, element_index, sample_value,
		last_element, output ready);
endinterface

interface ncs_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  best_index;
	logic [19:0] best_distance;
	modport source (output valid, best_index, best_distance, input ready);
	modport sink (input valid, best_index, best_distance, output ready);
endinterface

/* sv/ncs_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module ncs_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/ncs_cell.sv */
// one element cell: codebook column, query element, distance accumulate
// depends on ncs_pkg and ncs_ram
module ncs_cell import ncs_pkg::*; #(
	parameter int MAX_CODEWORDS = DEF_MAX_CODEWORDS,
	parameter int MAX_DIM       = DEF_MAX_DIM,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
	parameter int SUM_W         = 2 * DEF_SAMPLE_BITS + 5,
	parameter int ELEM          = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ncs_wr_t                          wr,
	input  logic [$clog2(MAX_DIM+1)-1:0]     len,
	input  logic                             vld_i,
	input  logic [$clog2(MAX_CODEWORDS)-1:0] idx_i,
	input  logic [SUM_W-1:0]                 sum_i,
	output logic                             vld_o,
	output logic [$clog2(MAX_CODEWORDS)-1:0] idx_o,
	output logic [SUM_W-1:0]                 sum_o
);
	localparam int AW = $clog2(MAX_CODEWORDS);
	localparam int SB = SAMPLE_BITS;

	logic [SB+7:0]      sample_ext;
	logic [SB-1:0]      sample;
	logic [AW+7:0]      cw_ext;
	logic               elem_hit;
	logic               ram_we;
	logic [SB-1:0]      q_q;
	logic [SB-1:0]      cb_data;
	logic               vld_s1;
	logic [AW-1:0]      idx_s1;
	logic [SUM_W-1:0]   sum_s1;
	logic [SB-1:0]      diff;
	logic [2*SB-1:0]    sq;
	logic               active;

	assign sample_ext = (SB+8)'(wr.sample);
	assign sample     = sample_ext[SB-1:0];
	assign cw_ext     = (AW+8)'(wr.cw);
	assign elem_hit   = (32'(wr.elem) == ELEM);
	assign ram_we     = wr.ld_we && elem_hit && (32'(wr.cw) < MAX_CODEWORDS);
	assign active     = (32'(len) > ELEM);

	ncs_ram #(.W(SB), .D(MAX_CODEWORDS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cw_ext[AW-1:0]),
		.wdata (sample),
		.raddr (idx_i),
		.rdata (cb_data)
	);

	always_ff @(posedge clk) begin
		if (wr.q_we && elem_hit) begin
			q_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_o  <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_o  <= vld_s1;
		end
	end

	assign diff = (cb_data > q_q) ? (cb_data - q_q) : (q_q - cb_data);
	assign sq   = diff * diff;

	always_ff @(posedge clk) begin
		idx_s1 <= idx_i;
		sum_s1 <= sum_i;
		idx_o  <= idx_s1;
		sum_o  <= active ? (sum_s1 + SUM_W'(sq)) : sum_s1;
	end
endmodule

/* sv/nearest_codeword_search.sv */
// nearest codeword search: row of element cells, issue sequencer, minimum tracker
// load items and query items without last_element are taken while idle and leave the block ready for the next item
// after the last query element a search issues one codeword address per cycle
// into the chain of two-stage cells
// reset clears control state and sets codeword_count and vector_length to full size
`include "assert_macros.svh"
module nearest_codeword_search import ncs_pkg::*; #(
	parameter int MAX_CODEWORDS = DEF_MAX_CODEWORDS,
	parameter int MAX_DIM       = DEF_MAX_DIM,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ncs_in_if.sink                req,
	ncs_out_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int AW    = $clog2(MAX_CODEWORDS);
	localparam int CW    = $clog2(MAX_CODEWORDS + 1);
	localparam int LW    = $clog2(MAX_DIM + 1);
	localparam int SUM_W = 2 * SAMPLE_BITS + $clog2(MAX_DIM + 1);
	localparam int CMPW  = (CW > 9) ? CW : 9;
	localparam int EW    = (SUM_W > DIST_W) ? SUM_W : DIST_W;

	ncs_state_t          state_q, state_d;
	logic [8:0]          count_cfg_q;
	logic [4:0]          len_cfg_q;
	logic [CMPW-1:0]     count_ext;
	logic [CW-1:0]       count_sat;
	logic [LW-1:0]       len_sat;
	logic [CW-1:0]       cnt_q;
	logic                acc;
	ncs_wr_t             wr;
	logic                vld_c [MAX_DIM+1];
	logic [AW-1:0]       idx_c [MAX_DIM+1];
	logic [SUM_W-1:0]    sum_c [MAX_DIM+1];
	logic                tl_vld;
	logic [AW-1:0]       tl_idx;
	logic [SUM_W-1:0]    tl_sum;
	logic                tl_final;
	logic [AW-1:0]       best_idx_q;
	logic [SUM_W-1:0]    best_sum_q;
	logic [AW+7:0]       best_idx_ext;
	logic [EW-1:0]       best_sum_ext;
	logic                out_vld_q;
	logic [7:0]          out_idx_q;
	logic [DIST_W-1:0]   out_dist_q;
	logic                out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_cfg_q <= 9'd256;
			len_cfg_q   <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CODEWORD_COUNT: count_cfg_q <= cfg_data;
				CFG_VECTOR_LENGTH:  len_cfg_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign count_ext = CMPW'(count_cfg_q);
	always_comb begin
		if (count_cfg_q == 9'd0) begin
			count_sat = CW'(1);
		end else if (count_ext > CMPW'(MAX_CODEWORDS)) begin
			count_sat = CW'(MAX_CODEWORDS);
		end else begin
			count_sat = CW'(count_ext);
		end
		if (len_cfg_q == 5'd0) begin
			len_sat = LW'(1);
		end else if (32'(len_cfg_q) > MAX_DIM) begin
			len_sat = LW'(MAX_DIM);
		end else begin
			len_sat = LW'(len_cfg_q);
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign wr.ld_we  = acc && (req.cmd == CMD_LOAD);
	assign wr.q_we   = acc && (req.cmd == CMD_QUERY);
	assign wr.cw     = req.codeword_index;
	assign wr.elem   = req.element_index;
	assign wr.sample = req.sample_value;

	assign vld_c[0] = (state_q == S_ISSUE);
	assign idx_c[0] = cnt_q[AW-1:0];
	assign sum_c[0] = '0;

	for (genvar e = 0; e < MAX_DIM; e++) begin : g_cell
		ncs_cell #(
			.MAX_CODEWORDS (MAX_CODEWORDS),
			.MAX_DIM       (MAX_DIM),
			.SAMPLE_BITS   (SAMPLE_BITS),
			.SUM_W         (SUM_W),
			.ELEM          (e)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.wr     (wr),
			.len    (len_sat),
			.vld_i  (vld_c[e]),
			.idx_i  (idx_c[e]),
			.sum_i  (sum_c[e]),
			.vld_o  (vld_c[e+1]),
			.idx_o  (idx_c[e+1]),
			.sum_o  (sum_c[e+1])
		);
	end

	assign tl_vld   = vld_c[MAX_DIM];
	assign tl_idx   = idx_c[MAX_DIM];
	assign tl_sum   = sum_c[MAX_DIM];
	assign tl_final = tl_vld && ((CW'(tl_idx) + CW'(1)) == count_sat);
	assign out_load = (state_q == S_DONE) && (!out_vld_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (wr.q_we && req.last_element) state_d = S_ISSUE;
			S_ISSUE: if ((cnt_q + CW'(1)) == count_sat) state_d = S_DRAIN;
			S_DRAIN: if (tl_final) state_d = S_DONE;
			S_DONE:  if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ISSUE) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tl_vld && (tl_idx == '0 || tl_sum < best_sum_q)) begin
			best_idx_q <= tl_idx;
			best_sum_q <= tl_sum;
		end
	end

	assign best_idx_ext = (AW+8)'(best_idx_q);
	assign best_sum_ext = EW'(best_sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= best_idx_ext[7:0];
			out_dist_q <= (best_sum_ext > EW'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
				: best_sum_ext[DIST_W-1:0];
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.best_index    = out_idx_q;
	assign rsp.best_distance = out_dist_q;

	`NCS_ASSERT_NEXT(a_search_start, clk, arst_n, wr.q_we && req.last_element, state_q == S_ISSUE)
	`NCS_ASSERT_SAME(a_tail_in_search, clk, arst_n, tl_vld, state_q == S_ISSUE || state_q == S_DRAIN)
	`NCS_ASSERT_SAME(a_issue_bound, clk, arst_n, state_q == S_ISSUE, cnt_q < count_sat)
endmodule
